FILE: hdl/interval_timer_three_counters_core_defines.svh
// ----------------------------------------------------------------------------
// Interval timer assertion macros
// Shared concurrent assertion forms used by the timer RTL.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_THREE_COUNTERS_CORE_DEFINES_SVH
`define INTERVAL_TIMER_THREE_COUNTERS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/itc_pkg.sv
// ----------------------------------------------------------------------------
// Interval timer package
// Word types, bus function codes and count constants of the timer.
// ----------------------------------------------------------------------------
package itc_pkg;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_GATE  = 2'd2,
		FUNC_TICK  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ACC_LATCH = 2'd0,
		ACC_LSB   = 2'd1,
		ACC_MSB   = 2'd2,
		ACC_WORD  = 2'd3
	} acc_t;

	localparam logic [1:0]  MODE_PORT  = 2'd3;
	localparam logic [16:0] CNT_BIN    = 17'h10000;
	localparam logic [16:0] CNT_BCD    = 17'd10000;
	localparam logic [7:0]  IDLE_BYTE  = 8'hff;

	typedef struct packed {
		func_t      func;
		logic [1:0] addr;
		logic [7:0] data;
		logic [2:0] tick_mask;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] out_levels;
		logic [2:0] irq_fired;
	} out_item_t;

	typedef struct packed {
		logic       rd_hit;
		logic [7:0] rd_byte;
		logic       level;
		logic       fired;
	} ctr_res_t;

endpackage

FILE: hdl/interval_timer_three_counters_core.sv
// A word accepted into the input register is processed from there, and its result word is
// registered in the output register; it stays in the input register while a result waits.
// Throughput: one word per cycle while out_ready stays high; the output register
// lets the next word be accepted while a result still waits.
// Reset: arst_n clears all counters (gates high), the interrupt enables and both valids.
// ----------------------------------------------------------------------------
// Interval timer core
// Three-counter interval timer with bus, gate and tick words on one channel.
// ----------------------------------------------------------------------------
`include "interval_timer_three_counters_core_defines.svh"

module interval_timer_three_counters_core
	import itc_pkg::*;
#(
	parameter int NUM_COUNTERS = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0] cfg_data
);

	logic       irq_enable_q;
	logic [2:0] irq_en_q;
	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res_s2;
	logic       valid_s2;
	logic       adv;
	ctr_res_t   res [NUM_COUNTERS];
	logic [NUM_COUNTERS-1:0] rd_hits;
	logic [7:0] rd_or;
	logic [2:0] levels;
	logic [2:0] fired;
	out_item_t  res_next;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q     <= 3'd0;
			irq_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			irq_en_q     <= cfg_data;
			irq_enable_q <= (cfg_data != 3'd0);
		end
	end

	for (genvar c = 0; c < NUM_COUNTERS; c++) begin : g_ctr
		itc_counter #(
			.IDX(c)
		) u_ctr (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.item  (item_s1),
			.irq_en(irq_en_q[c]),
			.res   (res[c])
		);
	end

	always_comb begin
		rd_or   = 8'd0;
		levels  = 3'd0;
		fired   = 3'd0;
		rd_hits = '0;
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			rd_hits[i] = res[i].rd_hit;
			rd_or      = rd_or | res[i].rd_byte;
			levels[i]  = res[i].level;
			fired[i]   = res[i].fired;
		end
		res_next.read_data  = (rd_hits != '0) ? rd_or : IDLE_BYTE;
		res_next.out_levels = levels;
		res_next.irq_fired  = fired;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	`ITC_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, adv, valid_s2, "Result lost after advance.")
	`ITC_ASSERT_NEXT(a_idle_byte, clk, arst_n, adv && (item_s1.func != FUNC_READ), res_s2.read_data == IDLE_BYTE, "Non-read word returned a data byte.")
	`ITC_ASSERT_NEXT(a_fire_tick_only, clk, arst_n, adv && (item_s1.func != FUNC_TICK), res_s2.irq_fired == 3'd0, "Interrupt fired outside a tick.")
	`ITC_ASSERT_SAME(a_one_reader, clk, arst_n, valid_s1, $onehot0(rd_hits), "More than one counter answered a read.")
	`ITC_ASSERT_SAME(a_fire_enabled, clk, arst_n, adv, (fired & ~irq_en_q) == 3'd0 && (irq_enable_q || fired == 3'd0), "Interrupt fired on a disabled counter.")

endmodule

FILE: hdl/itc_counter.sv
// ----------------------------------------------------------------------------
// Interval timer counter
// State and next-state logic of one counter for bus, gate and tick words.
// ----------------------------------------------------------------------------
module itc_counter
	import itc_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  in_item_t item,
	input  logic     irq_en,
	output ctr_res_t res
);

	localparam logic [1:0] IdxCode = 2'(IDX);

	acc_t        access_q, access_n;
	logic [2:0]  cmode_q, cmode_n;
	logic        bcd_q, bcd_n;
	logic        flip_q, flip_n;
	logic [15:0] reload_q, reload_n;
	logic [16:0] latched_q, latched_n;
	logic        out_q, out_n;
	logic        rpend_q, rpend_n;
	logic        gate_q, gate_n;
	logic [15:0] elapsed_q, elapsed_n;
	logic        expired_q, expired_n;
	logic [16:0] phase_q, phase_n;
	logic        running_q, running_n;

	logic        sel;
	logic        mode_hit;
	logic        lvl;
	logic [16:0] cnt_w;
	logic [16:0] diff_w;
	logic [16:0] period;
	logic [16:0] phase_inc;
	logic [16:0] cnt_n;
	logic        rd_hit_w;
	logic [7:0]  rd_byte_w;
	logic        level_w;
	logic        fired_w;

	assign sel      = (item.addr == IdxCode);
	assign mode_hit = (item.addr == MODE_PORT) && (item.data[7:6] == IdxCode);
	assign lvl      = (item.data != 8'd0);
	assign cnt_w    = (reload_q != 16'd0) ? {1'b0, reload_q} :
		(item.data[0] ? CNT_BCD : CNT_BIN);
	assign diff_w   = cnt_w - {1'b0, elapsed_q};
	assign period   = (reload_q != 16'd0) ? {1'b0, reload_q} : CNT_BIN;
	assign phase_inc = phase_q + 17'd1;

	always_comb begin
		access_n  = access_q;
		cmode_n   = cmode_q;
		bcd_n     = bcd_q;
		flip_n    = flip_q;
		reload_n  = reload_q;
		latched_n = latched_q;
		out_n     = out_q;
		rpend_n   = rpend_q;
		gate_n    = gate_q;
		elapsed_n = elapsed_q;
		expired_n = expired_q;
		phase_n   = phase_q;
		running_n = running_q;
		rd_hit_w  = 1'b0;
		rd_byte_w = 8'd0;
		fired_w   = 1'b0;
		unique case (item.func)
			FUNC_WRITE: begin
				if (mode_hit) begin
					access_n = acc_t'(item.data[5:4]);
					cmode_n  = item.data[3:1];
					bcd_n    = item.data[0];
					flip_n   = (acc_t'(item.data[5:4]) == ACC_MSB);
					if (acc_t'(item.data[5:4]) == ACC_LATCH) begin
						if (!expired_q && (cnt_w >= {1'b0, elapsed_q})) begin
							latched_n = diff_w;
						end else begin
							latched_n = {1'b0, diff_w[15:0]};
						end
					end
					if (item.data[3:1] == 3'd0) begin
						out_n = 1'b0;
					end
				end else if (sel) begin
					unique case (access_q)
						ACC_LATCH: begin
							flip_n = !flip_q;
							if (flip_q) begin
								access_n = ACC_WORD;
							end
						end
						ACC_LSB: reload_n = {8'd0, item.data};
						ACC_MSB: reload_n = {item.data, 8'd0};
						ACC_WORD: begin
							if (flip_q) begin
								reload_n = {item.data, reload_q[7:0]};
							end else begin
								reload_n = {reload_q[15:8], item.data};
							end
							flip_n = !flip_q;
						end
						default: ;
					endcase
					if (gate_q) begin
						elapsed_n = 16'd0;
						expired_n = 1'b0;
					end
					phase_n   = 17'd0;
					running_n = irq_en && gate_q;
				end
			end
			FUNC_READ: begin
				if (sel) begin
					rd_hit_w = 1'b1;
					unique case (access_q)
						ACC_LATCH: begin
							rd_byte_w = flip_q ? latched_q[15:8] : latched_q[7:0];
							flip_n = !flip_q;
							if (flip_q) begin
								access_n = ACC_WORD;
							end
						end
						ACC_LSB: rd_byte_w = reload_q[7:0];
						ACC_MSB: rd_byte_w = reload_q[15:8];
						ACC_WORD: begin
							rd_byte_w = flip_q ? reload_q[15:8] : reload_q[7:0];
							flip_n = !flip_q;
						end
						default: ;
					endcase
				end
			end
			FUNC_GATE: begin
				if (sel && (lvl != gate_q)) begin
					gate_n = lvl;
					unique case (cmode_q)
						3'd0, 3'd4: begin
							phase_n   = 17'd0;
							running_n = irq_en && lvl;
						end
						3'd1: begin
							if (lvl) begin
								rpend_n = 1'b1;
							end
						end
						3'd2, 3'd6: begin
							if (lvl) begin
								elapsed_n = 16'd0;
								expired_n = 1'b0;
								phase_n   = 17'd0;
								running_n = irq_en;
							end else begin
								out_n = 1'b1;
							end
						end
						3'd3, 3'd7: begin
							if (!lvl) begin
								out_n = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			FUNC_TICK: begin
				if (item.tick_mask[IDX]) begin
					if (elapsed_q == 16'hffff) begin
						elapsed_n = 16'd0;
						expired_n = 1'b1;
					end else begin
						elapsed_n = elapsed_q + 16'd1;
					end
					if (running_q) begin
						if (phase_inc >= period) begin
							phase_n = 17'd0;
							if (rpend_q) begin
								rpend_n = 1'b0;
								out_n   = 1'b0;
							end else begin
								out_n = 1'b1;
							end
							fired_w = irq_en;
						end else begin
							phase_n = phase_inc;
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign cnt_n = (reload_n != 16'd0) ? {1'b0, reload_n} : (bcd_n ? CNT_BCD : CNT_BIN);

	always_comb begin
		if (irq_en) begin
			level_w = out_n;
		end else if (cmode_n != 3'd0) begin
			level_w = 1'b0;
		end else if (expired_n) begin
			level_w = (cnt_n != CNT_BIN) || (elapsed_n != 16'd0);
		end else begin
			level_w = ({1'b0, elapsed_n} > cnt_n);
		end
	end

	assign res = {rd_hit_w, rd_byte_w, level_w, fired_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_q  <= ACC_LATCH;
			cmode_q   <= 3'd0;
			bcd_q     <= 1'b0;
			flip_q    <= 1'b0;
			reload_q  <= 16'd0;
			latched_q <= 17'd0;
			out_q     <= 1'b0;
			rpend_q   <= 1'b0;
			gate_q    <= 1'b1;
			elapsed_q <= 16'd0;
			expired_q <= 1'b0;
			phase_q   <= 17'd0;
			running_q <= 1'b0;
		end else if (adv) begin
			access_q  <= access_n;
			cmode_q   <= cmode_n;
			bcd_q     <= bcd_n;
			flip_q    <= flip_n;
			reload_q  <= reload_n;
			latched_q <= latched_n;
			out_q     <= out_n;
			rpend_q   <= rpend_n;
			gate_q    <= gate_n;
			elapsed_q <= elapsed_n;
			expired_q <= expired_n;
			phase_q   <= phase_n;
			running_q <= running_n;
		end
	end

endmodule
